/* sv/page_bitmap_allocator_macros.svh */
// Assertion macros used by the file that checks this block.
`ifndef PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PBA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page bitmap allocator check failed");
`define PBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page bitmap allocator check failed");
`else
`define PBA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/pba_pkg.sv */
package pba_pkg;

  localparam int DATA_W          = 64;
  localparam int COUNT_W         = 13;
  localparam int CFG_IDX_W       = 3;
  localparam int PAGE_SHIFT      = 12;
  localparam int NUM_REGIONS_DEF = 2;
  localparam int MAX_PAGES_DEF   = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION0_BASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION0_PAGES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION1_BASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION1_PAGES = 3'd4;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE1 = 2'd2,
    ACT_FREER = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [DATA_W-1:0]   target_addr;
    logic [COUNT_W-1:0]  page_count;
  } req_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_address;
    logic              ok;
  } rsp_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_INIT,
    S_SREG,
    S_SRD,
    S_SCHUNK,
    S_HIT,
    S_FREE,
    S_MRD,
    S_MWR,
    S_FIN_OK,
    S_FIN_FAIL
  } state_t;

  typedef struct packed {
    logic start;
    logic next_region;
    logic init_write;
    logic scan_read;
    logic scan_chunk;
    logic hit_setup;
    logic free_setup;
    logic mark_read;
    logic mark_write;
    logic finish;
    logic finish_ok;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    region_end;
    logic    region_empty;
    logic    count_zero;
    logic    init_skip;
    logic    chunk_found;
    logic    chunk_last;
    logic    word_end;
    logic    contained;
    logic    range_fits;
    logic    mark_last;
    logic    out_busy;
  } sts_t;

endpackage

/* sv/pba_stream_if.sv */
interface pba_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/pba_ram.sv */
module pba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* sv/pba_ctrl.sv */
module pba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pba_pkg::sts_t sts,
  output pba_pkg::cmd_t cmd
);
  pba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pba_pkg::S_IDLE: begin
        if (in_valid) state_next = pba_pkg::S_DISP;
      end
      pba_pkg::S_DISP: begin
        unique case (sts.action)
          pba_pkg::ACT_INIT:  state_next = pba_pkg::S_INIT;
          pba_pkg::ACT_ALLOC: state_next = sts.count_zero ? pba_pkg::S_FIN_FAIL
                                                          : pba_pkg::S_SREG;
          default:            state_next = pba_pkg::S_FREE;
        endcase
      end
      pba_pkg::S_INIT: begin
        if (sts.region_end) state_next = pba_pkg::S_FIN_OK;
      end
      pba_pkg::S_SREG: begin
        if (sts.region_end) state_next = pba_pkg::S_FIN_FAIL;
        else if (!sts.region_empty) state_next = pba_pkg::S_SRD;
      end
      pba_pkg::S_SRD: state_next = pba_pkg::S_SCHUNK;
      pba_pkg::S_SCHUNK: begin
        if (sts.chunk_found) state_next = pba_pkg::S_HIT;
        else if (sts.chunk_last) state_next = pba_pkg::S_SREG;
        else if (sts.word_end) state_next = pba_pkg::S_SRD;
      end
      pba_pkg::S_HIT: state_next = pba_pkg::S_MRD;
      pba_pkg::S_FREE: begin
        if (sts.region_end) begin
          state_next = pba_pkg::S_FIN_FAIL;
        end else if (sts.contained) begin
          if (sts.action == pba_pkg::ACT_FREE1) state_next = pba_pkg::S_MRD;
          else if (sts.range_fits) begin
            state_next = sts.count_zero ? pba_pkg::S_FIN_OK : pba_pkg::S_MRD;
          end
        end
      end
      pba_pkg::S_MRD: state_next = pba_pkg::S_MWR;
      pba_pkg::S_MWR: begin
        state_next = sts.mark_last ? pba_pkg::S_FIN_OK : pba_pkg::S_MRD;
      end
      pba_pkg::S_FIN_OK, pba_pkg::S_FIN_FAIL: begin
        if (!sts.out_busy) state_next = pba_pkg::S_IDLE;
      end
      default: state_next = pba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      pba_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      pba_pkg::S_INIT: begin
        if (!sts.region_end) begin
          if (sts.init_skip) cmd.next_region = 1'b1;
          else cmd.init_write = 1'b1;
        end
      end
      pba_pkg::S_SREG: begin
        if (!sts.region_end && sts.region_empty) cmd.next_region = 1'b1;
      end
      pba_pkg::S_SRD: cmd.scan_read = 1'b1;
      pba_pkg::S_SCHUNK: begin
        if (!sts.chunk_found && sts.chunk_last) cmd.next_region = 1'b1;
        else cmd.scan_chunk = 1'b1;
      end
      pba_pkg::S_HIT: cmd.hit_setup = 1'b1;
      pba_pkg::S_FREE: begin
        if (!sts.region_end) begin
          if (!sts.contained) cmd.next_region = 1'b1;
          else if (sts.action == pba_pkg::ACT_FREE1) cmd.free_setup = 1'b1;
          else if (!sts.range_fits) cmd.next_region = 1'b1;
          else if (!sts.count_zero) cmd.free_setup = 1'b1;
        end
      end
      pba_pkg::S_MRD: cmd.mark_read = 1'b1;
      pba_pkg::S_MWR: cmd.mark_write = 1'b1;
      pba_pkg::S_FIN_OK: begin
        cmd.finish    = !sts.out_busy;
        cmd.finish_ok = 1'b1;
      end
      pba_pkg::S_FIN_FAIL: cmd.finish = !sts.out_busy;
      default: ;
    endcase
  end
endmodule

/* sv/pba_datapath.sv */
module pba_datapath #(
  parameter int NUM_REGIONS = pba_pkg::NUM_REGIONS_DEF,
  parameter int MAX_PAGES   = pba_pkg::MAX_PAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pba_pkg::DATA_W-1:0]       cfg_data,
  input  pba_pkg::req_item_t               req_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pba_pkg::rsp_item_t               out_data,
  input  pba_pkg::cmd_t                    cmd,
  output pba_pkg::sts_t                    sts
);
  localparam int WPR   = MAX_PAGES / 64;
  localparam int TOTAL = NUM_REGIONS * WPR;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int PW    = $clog2(MAX_PAGES + 1);
  localparam int WCW   = PW - 5;
  localparam int CW    = pba_pkg::COUNT_W;
  localparam int SW    = ((PW > CW) ? PW : CW) + 1;
  localparam int DW    = pba_pkg::DATA_W;

  logic [1:0]    rcount;
  logic [DW-1:0] base [2];
  logic [CW-1:0] pages_r [2];

  pba_pkg::action_t act;
  logic [DW-1:0]    addr;
  logic [CW-1:0]    cnt;

  logic [1:0]     r;
  logic [PW:0]    pg;
  logic [CW-1:0]  run;
  logic [PW-1:0]  lo, hi;
  logic [WCW-1:0] wc;

  logic [TOTAL-1:0] wvalid;
  logic             vq;
  logic             we, re;
  logic [AW-1:0]    waddr, raddr, wbase;
  logic [DW-1:0]    wdata, rdata, word;

  logic [1:0]     n_use;
  logic [CW-1:0]  pg13;
  logic [PW-1:0]  pages_eff;
  logic [DW-1:0]  base_cur;
  logic [WCW-1:0] words;

  logic [CW-1:0]  run_c;
  logic           found_c;
  logic [PW-1:0]  end_c;
  logic [PW:0]    p;

  logic [DW:0]    diff;
  logic           contained;
  logic [PW-1:0]  idx;
  logic [PW-1:0]  hit_lo;
  logic [PW-1:0]  free_hi;

  logic [5:0]     lo_bit, hi_bit;
  logic           mark_last;
  logic [DW-1:0]  mask;

  assign n_use     = (32'(rcount) > NUM_REGIONS) ? 2'(NUM_REGIONS) : rcount;
  assign pg13      = pages_r[r[0]];
  assign pages_eff = (32'(pg13) > MAX_PAGES) ? PW'(MAX_PAGES) : PW'(pg13);
  assign base_cur  = base[r[0]];
  assign wbase     = r[0] ? AW'(WPR) : '0;
  assign words     = WCW'(((PW + 1)'(pages_eff) + (PW + 1)'(63)) >> 6);
  assign word      = rdata & {DW{vq}};

  always_comb begin
    run_c   = run;
    found_c = 1'b0;
    end_c   = '0;
    p       = '0;
    for (int k = 0; k < 8; k++) begin
      p = pg + (PW + 1)'(k);
      if (p < {1'b0, pages_eff} && !found_c) begin
        if (word[{pg[5:3], 3'(k)}]) begin
          run_c = run_c + CW'(1);
          if (run_c == cnt) begin
            found_c = 1'b1;
            end_c   = p[PW-1:0];
          end
        end else begin
          run_c = '0;
        end
      end
    end
  end

  assign diff      = {1'b0, addr} - {1'b0, base_cur};
  assign contained = !diff[DW] &&
                     (diff[DW-1:pba_pkg::PAGE_SHIFT] <
                      (DW - pba_pkg::PAGE_SHIFT)'(pages_eff));
  assign idx       = diff[pba_pkg::PAGE_SHIFT+PW-1:pba_pkg::PAGE_SHIFT];
  assign hit_lo    = PW'(SW'(hi) + SW'(1) - SW'(cnt));
  assign free_hi   = (act == pba_pkg::ACT_FREE1) ? idx
                                                 : PW'(SW'(idx) + SW'(cnt) - SW'(1));

  assign mark_last = (wc == WCW'(hi[PW-1:6]));
  assign lo_bit    = (wc == WCW'(lo[PW-1:6])) ? lo[5:0] : 6'd0;
  assign hi_bit    = mark_last ? hi[5:0] : 6'd63;
  assign mask      = ({DW{1'b1}} << lo_bit) & ({DW{1'b1}} >> (6'd63 - hi_bit));

  assign we    = cmd.init_write || cmd.mark_write;
  assign re    = cmd.scan_read || cmd.mark_read;
  assign waddr = wbase + AW'(wc);
  assign raddr = wbase + (cmd.scan_read ? AW'(pg[PW:6]) : AW'(wc));
  always_comb begin
    if (cmd.init_write) wdata = (wc == '0) ? ~DW'(1) : '1;
    else if (act == pba_pkg::ACT_ALLOC) wdata = word & ~mask;
    else wdata = word | mask;
  end

  pba_ram #(.WIDTH(DW), .DEPTH(TOTAL)) u_bitmap (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
    end else if (we) begin
      wvalid[waddr] <= 1'b1;
    end
    if (re) begin
      vq <= wvalid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcount     <= '0;
      base[0]    <= '0;
      base[1]    <= '0;
      pages_r[0] <= '0;
      pages_r[1] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pba_pkg::REG_REGION_COUNT:  rcount     <= cfg_data[1:0];
        pba_pkg::REG_REGION0_BASE:  base[0]    <= cfg_data;
        pba_pkg::REG_REGION0_PAGES: pages_r[0] <= cfg_data[CW-1:0];
        pba_pkg::REG_REGION1_BASE:  base[1]    <= cfg_data;
        pba_pkg::REG_REGION1_PAGES: pages_r[1] <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act  <= req_data.action;
      addr <= req_data.target_addr;
      cnt  <= req_data.page_count;
      r    <= '0;
      wc   <= '0;
      pg   <= '0;
      run  <= '0;
    end
    if (cmd.next_region) begin
      r   <= r + 2'd1;
      wc  <= '0;
      pg  <= '0;
      run <= '0;
    end
    if (cmd.init_write || cmd.mark_write) begin
      wc <= wc + WCW'(1);
    end
    if (cmd.scan_chunk) begin
      pg  <= pg + (PW + 1)'(8);
      run <= run_c;
      if (found_c) hi <= end_c;
    end
    if (cmd.hit_setup) begin
      lo <= hit_lo;
      wc <= WCW'(hit_lo[PW-1:6]);
    end
    if (cmd.free_setup) begin
      lo <= idx;
      hi <= free_hi;
      wc <= WCW'(idx[PW-1:6]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.finish) begin
      out_data.ok <= cmd.finish_ok;
      out_data.result_address <= (act == pba_pkg::ACT_ALLOC && cmd.finish_ok)
                                 ? base_cur + (DW'(lo) << pba_pkg::PAGE_SHIFT) : '0;
    end
  end

  always_comb begin
    sts              = '0;
    sts.action       = act;
    sts.region_end   = r >= n_use;
    sts.region_empty = pages_eff == '0;
    sts.count_zero   = cnt == '0;
    sts.init_skip    = (pages_eff == '0) || (wc >= words);
    sts.chunk_found  = found_c;
    sts.chunk_last   = (pg + (PW + 1)'(8)) >= {1'b0, pages_eff};
    sts.word_end     = pg[5:3] == 3'd7;
    sts.contained    = contained;
    sts.range_fits   = (SW'(idx) + SW'(cnt)) <= SW'(pages_eff);
    sts.mark_last    = mark_last;
    sts.out_busy     = out_valid && !out_ready;
  end
endmodule

/* sv/page_bitmap_allocator.sv */
// First-fit page allocator over up to two regions, one free bit per 4096-byte
// page, held in a bitmap RAM of 64-bit words with one read and one write port.
// Request handling is paced by that RAM and by an 8-page scan step: init
// writes one word per cycle, ceil(pages/64) words per region; allocate
// reads each 64-page word once and then takes up to eight 8-page steps on
// it, then marks the found run with a read and a write per word; free
// checks one region at a time, then reads and writes each word it touches.
// Each request also passes a dispatch state and a finish state that waits
// for a free result slot. No clearing pass is needed after reset.
`include "page_bitmap_allocator_macros.svh"
module page_bitmap_allocator #(
  parameter int NUM_REGIONS = pba_pkg::NUM_REGIONS_DEF,
  parameter int MAX_PAGES   = pba_pkg::MAX_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pba_pkg::DATA_W-1:0]    cfg_data,
  pba_stream_if.sink                    req,
  pba_stream_if.source                  rsp
);
  pba_pkg::cmd_t      cmd;
  pba_pkg::sts_t      sts;
  logic               in_ready;
  logic               out_valid;
  pba_pkg::rsp_item_t out_data;

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  pba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  pba_datapath #(.NUM_REGIONS(NUM_REGIONS), .MAX_PAGES(MAX_PAGES)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req_data (req.data),
    .out_valid(out_valid),
    .out_ready(rsp.ready),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

  `PBA_ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)
  `PBA_ASSERT_IMPLY(a_finish_slot_free, clk, rst, cmd.finish, !(rsp.valid && !rsp.ready))
  `PBA_ASSERT_IMPLY(a_fail_zero_addr, clk, rst, rsp.valid && !rsp.data.ok, rsp.data.result_address == '0)
endmodule
